@@ src/slxfp_pkg.sv @@
package slxfp_pkg;

	// Header bytes of a frame
	localparam logic [7:0] SYNC_U   = 8'h55;
	localparam logic [7:0] SYNC_N   = 8'h4E;
	localparam logic [7:0] SYNC_E   = 8'h45;
	localparam logic [7:0] SYNC_R   = 8'h52;
	localparam logic [7:0] PAD_BYTE = 8'h00;
	localparam logic [7:0] COLON    = 8'h3A;

	// XOR of all fixed header bytes; the length byte is folded in on top
	localparam logic [7:0] SEED_XOR = SYNC_U ^ SYNC_N ^ SYNC_E ^ SYNC_R ^ PAD_BYTE ^ COLON;

	// One result request
	typedef struct packed {
		logic [7:0] body_byte;
		logic       is_last;
		logic       checksum_ok;
	} result_t;

endpackage

@@ src/slxfp_parse.sv @@
module slxfp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [7:0]        item_byte,
	input  logic              res_space,
	output logic              item_take,
	output logic              res_load,
	output slxfp_pkg::result_t res
);
	import slxfp_pkg::*;

	typedef enum logic [2:0] {
		PH_SYNC_U, PH_SYNC_N, PH_SYNC_E, PH_SYNC_R,
		PH_LEN, PH_PAD, PH_COLON, PH_BODY
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] running_xor_q, running_xor_d;
	logic [7:0] left_dec;
	logic       in_body;

	// A body byte needs room in the result register; header bytes never stall
	assign in_body   = (phase_q == PH_BODY);
	assign item_take = item_valid && (!in_body || res_space);
	assign res_load  = item_take && in_body;
	assign left_dec  = bytes_left_q - 8'd1;

	// Result fields
	always_comb begin
		res.body_byte   = item_byte;
		res.is_last     = (left_dec == 8'd0);
		res.checksum_ok = (left_dec == 8'd0) && (running_xor_q == item_byte);
	end

	// Next-state logic
	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		running_xor_d = running_xor_q;
		unique case (phase_q)
			PH_SYNC_U: phase_d = (item_byte == SYNC_U) ? PH_SYNC_N : PH_SYNC_U;
			PH_SYNC_N: phase_d = (item_byte == SYNC_N) ? PH_SYNC_E : PH_SYNC_U;
			PH_SYNC_E: phase_d = (item_byte == SYNC_E) ? PH_SYNC_R : PH_SYNC_U;
			PH_SYNC_R: phase_d = (item_byte == SYNC_R) ? PH_LEN : PH_SYNC_U;
			PH_LEN: begin
				bytes_left_d = item_byte;
				phase_d      = PH_PAD;
			end
			PH_PAD:    phase_d = (item_byte == PAD_BYTE) ? PH_COLON : PH_SYNC_U;
			PH_COLON: begin
				if (item_byte == COLON) begin
					running_xor_d = SEED_XOR ^ bytes_left_q;
					phase_d       = PH_BODY;
				end else begin
					phase_d = PH_SYNC_U;
				end
			end
			PH_BODY: begin
				// first byte of a zero-length frame is not folded (count wraps)
				if (bytes_left_q > 8'd1) begin
					running_xor_d = running_xor_q ^ item_byte;
				end
				bytes_left_d = left_dec;
				if (left_dec == 8'd0) begin
					phase_d = PH_SYNC_U;
				end
			end
			default: phase_d = PH_SYNC_U;
		endcase
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SYNC_U;
			bytes_left_q  <= 8'd0;
			running_xor_q <= 8'd0;
		end else if (item_take) begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			running_xor_q <= running_xor_d;
		end
	end

endmodule

@@ src/slxfp_out_reg.sv @@
module slxfp_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  slxfp_pkg::result_t din,
	output logic               space,
	output logic               res_valid,
	input  logic               res_ready,
	output slxfp_pkg::result_t dout
);
	import slxfp_pkg::*;

	logic    valid_q;
	result_t data_q;

	// Room when empty or when the held request leaves this cycle
	assign space     = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign dout      = data_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

@@ src/sync_length_xor_frame_parser.sv @@
// Byte-serial frame parser for frames of the form: four sync bytes, a length
// byte, 0x00, ':', then "length" body bytes, the last of which is an XOR
// checksum over the header, the length and the preceding body bytes.
//
// Channels: rx_valid/rx_ready/rx_byte carries received bytes in;
// res_valid/res_ready/body_byte/is_last/checksum_ok carries one request per
// body byte out. Header bytes produce no output. The final body byte has
// is_last set and checksum_ok telling whether it matched the running XOR.
//
// Path: an accepted byte sits in the input register, then a body byte moves
// into the result register, whose res_valid then rises; a full result register
// holds it back in the input register. Throughput is one byte per cycle while
// the receiver does not stall, set by the parser state update between the two.
//
// Reset (arst_n low) empties both registers and returns the parser to the
// hunt for the first sync byte with count and XOR cleared. When the receiver
// stalls, the result register holds its request; header bytes keep flowing,
// and a body byte waits in the input register, after which rx_ready drops.
module sync_length_xor_frame_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] body_byte,
	output logic       is_last,
	output logic       checksum_ok
);
	import slxfp_pkg::*;

	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       item_take;
	logic       res_load;
	logic       res_space;
	result_t    res_d;
	result_t    res_q;

	// Input register
	assign rx_ready = !byte_valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			byte_valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame state and result formation
	slxfp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (byte_valid_s1),
		.item_byte  (byte_s1),
		.res_space  (res_space),
		.item_take  (item_take),
		.res_load   (res_load),
		.res        (res_d)
	);

	// Result register
	slxfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.din       (res_d),
		.space     (res_space),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.dout      (res_q)
	);

	assign body_byte   = res_q.body_byte;
	assign is_last     = res_q.is_last;
	assign checksum_ok = res_q.checksum_ok;

	// A good checksum is only ever reported on the closing byte
	a_ok_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && checksum_ok |-> is_last)
		else $error("checksum_ok set on a non-final body byte");

	// A byte waiting in the input register is neither lost nor altered
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid_s1 && !item_take |=> byte_valid_s1 && $stable(byte_s1))
		else $error("pending input byte dropped or changed");

	// Input back-pressure only comes from a stalled result register
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> byte_valid_s1 && res_valid && !res_ready)
		else $error("rx_ready low without an output stall");

	// A result is loaded only when the result register has room
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> res_space)
		else $error("result register overwritten");

endmodule

@@ tb/sync_length_xor_frame_parser_tb.sv @@
`timescale 1ns / 100ps

module sync_length_xor_frame_parser_tb;

	import slxfp_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 10;

	// Parser phase codes: the start of the sync hunt and the phases after it
	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_LEN   = 3'd4;
	localparam logic [2:0] PH_PAD   = 3'd5;
	localparam logic [2:0] PH_COLON = 3'd6;
	localparam logic [2:0] PH_BODY  = 3'd7;

	// Tracks the frame state and holds the body byte requests still due out
	class body_scoreboard;
		logic [2:0] phase;
		logic [7:0] bytes_left;
		logic [7:0] run_xor;
		logic [7:0] sync_seq [4];
		result_t    expected_body_q [$];
		int         errors;

		function new();
			phase      = PH_HUNT;
			bytes_left = 8'h00;
			run_xor    = 8'h00;
			sync_seq   = '{SYNC_U, SYNC_N, SYNC_E, SYNC_R};
			errors     = 0;
		endfunction

		// Advance the frame tracker by one accepted byte
		function void note_rx_byte(logic [7:0] b);
			result_t r;
			case (phase)
				PH_LEN: begin
					bytes_left = b;
					phase      = PH_PAD;
				end
				PH_PAD: phase = (b == PAD_BYTE) ? PH_COLON : PH_HUNT;
				PH_COLON: begin
					if (b == COLON) begin
						run_xor = SEED_XOR ^ bytes_left;
						phase   = PH_BODY;
					end else begin
						phase = PH_HUNT;
					end
				end
				PH_BODY: begin
					// checksum byte itself is never folded in
					if (bytes_left > 8'd1)
						run_xor = run_xor ^ b;
					bytes_left    = bytes_left - 8'd1;
					r.body_byte   = b;
					r.is_last     = (bytes_left == 8'd0);
					r.checksum_ok = r.is_last && (run_xor == b);
					if (r.is_last)
						phase = PH_HUNT;
					expected_body_q.push_back(r);
				end
				default: begin
					// sync hunt: a miss drops back without retesting the byte
					if (b == sync_seq[phase[1:0]])
						phase = phase + 3'd1;
					else
						phase = PH_HUNT;
				end
			endcase
		endfunction

		// Compare one output request with the oldest expected one
		function void check_result(logic [7:0] bb, logic lst, logic ok);
			result_t want;
			if (expected_body_q.size() == 0) begin
				$display("%0t: unexpected request, body_byte %02h is_last %0b checksum_ok %0b",
					$time, bb, lst, ok);
				errors++;
				return;
			end
			want = expected_body_q.pop_front();
			if (want.body_byte !== bb) begin
				$display("%0t: body_byte mismatch, expected %02h, got %02h",
					$time, want.body_byte, bb);
				errors++;
			end
			if (want.is_last !== lst) begin
				$display("%0t: is_last mismatch, expected %0b, got %0b",
					$time, want.is_last, lst);
				errors++;
			end
			if (want.checksum_ok !== ok) begin
				$display("%0t: checksum_ok mismatch, expected %0b, got %0b",
					$time, want.checksum_ok, ok);
				errors++;
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       rx_valid  = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte   = 8'h00;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic [7:0] body_byte;
	logic       is_last;
	logic       checksum_ok;

	body_scoreboard sb;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int sent_count   = 0;
	int cycle_count  = 0;

	sync_length_xor_frame_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.body_byte   (body_byte),
		.is_last     (is_last),
		.checksum_ok (checksum_ok)
	);

	always #CLK_HALF clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: run limit reached", $time);
			$display("sync_length_xor_frame_parser_tb failed");
			$finish;
		end
	end

	// Receiver: check accepted requests, stall at random
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(body_byte, is_last, checksum_ok);
		res_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// Present one byte, optionally after idle cycles, and wait for acceptance
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!rx_ready);
		sb.note_rx_byte(b);
		sent_count++;
	endtask

	// Whole frame; bad_pos >= 0 corrupts that header byte
	task automatic send_frame(input int len, input bit good_sum, input int bad_pos);
		logic [7:0] hdr [7];
		logic [7:0] x;
		logic [7:0] b;
		int         n;
		hdr = '{SYNC_U, SYNC_N, SYNC_E, SYNC_R, len[7:0], PAD_BYTE, COLON};
		if (bad_pos >= 0)
			hdr[bad_pos] = hdr[bad_pos] ^ 8'($urandom_range(1, 255));
		foreach (hdr[i])
			send_byte(hdr[i]);
		// zero length wraps to 256 body bytes, the first one unfolded
		n = (len == 0) ? 256 : len;
		x = SEED_XOR ^ len[7:0];
		for (int i = 0; i < n - 1; i++) begin
			b = 8'($urandom_range(0, 255));
			if (i > 0 || len != 0)
				x = x ^ b;
			send_byte(b);
		end
		if (good_sum)
			send_byte(x);
		else
			send_byte(x ^ 8'($urandom_range(1, 255)));
	endtask

	function automatic int pick_len();
		if ($urandom_range(0, 99) < 92)
			return $urandom_range(1, 8);
		return $urandom_range(9, 40);
	endfunction

	// Mix of well-formed frames, broken headers and line noise
	task automatic run_traffic(input int quota);
		int stop_at;
		int r;
		int p;
		int k;
		stop_at = sent_count + quota;
		while (sent_count < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				k = $urandom_range(1, 5);
				repeat (k) begin
					if ($urandom_range(0, 3) == 0)
						send_byte(SYNC_U);
					else
						send_byte(8'($urandom_range(0, 255)));
				end
			end else if (r < 22) begin
				// length byte takes anything, so never corrupt it
				p = $urandom_range(0, 5);
				if (p >= 4)
					p++;
				send_frame(pick_len(), 1'b1, p);
			end else begin
				send_frame(pick_len(), ($urandom_range(0, 99) < 70), -1);
			end
		end
	endtask

	initial begin
		logic [7:0] seq [$];
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: repeated 'U' is not retested, then a length-one frame
		tx_idle_pct  = 6;
		rx_stall_pct = 82;
		seq = '{SYNC_U, SYNC_U, SYNC_N, SYNC_E, SYNC_R};
		foreach (seq[i])
			send_byte(seq[i]);
		send_frame(1, 1'b1, -1);
		// bad colon after a max length, then bad pad byte
		seq = '{SYNC_U, SYNC_N, SYNC_E, SYNC_R, 8'hFF, PAD_BYTE, PAD_BYTE,
			SYNC_U, SYNC_N, SYNC_E, SYNC_R, 8'h02, 8'h01};
		foreach (seq[i])
			send_byte(seq[i]);

		// Random traffic under three idle patterns
		run_traffic(450);
		tx_idle_pct  = 82;
		rx_stall_pct = 6;
		run_traffic(450);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_frame(0, 1'b1, -1);
		send_frame(255, 1'b1, -1);
		run_traffic(200);
		rx_valid <= 1'b0;

		// Drain
		while (sb.expected_body_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.expected_body_q.size() != 0) begin
			$display("%0t: %0d requests never came out", $time, sb.expected_body_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("sync_length_xor_frame_parser_tb passed");
		else
			$display("sync_length_xor_frame_parser_tb failed");
		$finish;
	end

endmodule

@@ sync_length_xor_frame_parser.f @@
src/slxfp_pkg.sv
src/slxfp_parse.sv
src/slxfp_out_reg.sv
src/sync_length_xor_frame_parser.sv
tb/sync_length_xor_frame_parser_tb.sv
